/* hw/rtl/m3i_pkg.sv */
`default_nettype none
package m3i_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SING = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam int NUM_ELEM = 9;

endpackage
`default_nettype wire

/* hw/rtl/m3i_cofactor.sv */
`default_nettype none
module m3i_cofactor import m3i_pkg::*; #(
  parameter int EB = 32
) (
  input  wire logic                              clk,
  input  wire logic [1:0]                        en,
  input  wire logic [NUM_ELEM-1:0][EB-1:0]       e,
  output logic      [NUM_ELEM-1:0][2*EB:0]       cof,
  output logic      [2:0][EB-1:0]                row0
);

  localparam int PW = 2 * EB;
  localparam int CW = 2 * EB + 1;

  logic [NUM_ELEM-1:0][PW-1:0] pa_r;
  logic [NUM_ELEM-1:0][PW-1:0] pb_r;
  logic [NUM_ELEM-1:0][CW-1:0] cof_r;
  logic [2:0][EB-1:0]          row0_a_r;
  logic [2:0][EB-1:0]          row0_b_r;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      localparam int K  = i * 3 + j;

      logic signed [PW-1:0] pa_w;
      logic signed [PW-1:0] pb_w;
      logic signed [CW-1:0] c_w;

      assign pa_w = $signed(e[I1*3+J1]) * $signed(e[I2*3+J2]);
      assign pb_w = $signed(e[I1*3+J2]) * $signed(e[I2*3+J1]);
      assign c_w  = $signed({pa_r[K][PW-1], pa_r[K]}) - $signed({pb_r[K][PW-1], pb_r[K]});

      always_ff @(posedge clk) begin
        if (en[0]) begin
          pa_r[K] <= pa_w;
          pb_r[K] <= pb_w;
        end
        if (en[1]) begin
          cof_r[K] <= c_w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      row0_a_r <= e[2:0];
    end
    if (en[1]) begin
      row0_b_r <= row0_a_r;
    end
  end

  assign cof  = cof_r;
  assign row0 = row0_b_r;

endmodule
`default_nettype wire

/* hw/rtl/m3i_det.sv */
`default_nettype none
module m3i_det import m3i_pkg::*; #(
  parameter int EB = 32
) (
  input  wire logic                           clk,
  input  wire logic [2:0]                     en,
  input  wire logic [NUM_ELEM-1:0][2*EB:0]    cof_in,
  input  wire logic [2:0][EB-1:0]             row0,
  output logic      [NUM_ELEM-1:0][2*EB:0]    cof_out,
  output logic      [3*EB+3:0]                det
);

  localparam int CW = 2 * EB + 1;
  localparam int QW = 2 * EB + 1;
  localparam int SW = QW + 2;
  localparam int DW = 3 * EB + 4;

  logic [2:0][QW-1:0]          pl_r;
  logic [2:0][QW-1:0]          ph_r;
  logic [SW-1:0]               sl_r;
  logic [SW-1:0]               sh_r;
  logic [DW-1:0]               det_r;
  logic [NUM_ELEM-1:0][CW-1:0] c3_r;
  logic [NUM_ELEM-1:0][CW-1:0] c4_r;
  logic [NUM_ELEM-1:0][CW-1:0] c5_r;

  // Split each first-row cofactor into an unsigned low half and a signed high half
  for (genvar k = 0; k < 3; k++) begin : g_pp
    logic signed [QW-1:0] pl_w;
    logic signed [QW-1:0] ph_w;

    assign pl_w = $signed(row0[k]) * $signed({1'b0, cof_in[k][EB-1:0]});
    assign ph_w = $signed(row0[k]) * $signed(cof_in[k][CW-1:EB]);

    always_ff @(posedge clk) begin
      if (en[0]) begin
        pl_r[k] <= pl_w;
        ph_r[k] <= ph_w;
      end
    end
  end

  logic signed [SW-1:0] sl_w;
  logic signed [SW-1:0] sh_w;
  logic signed [DW-1:0] det_w;

  assign sl_w  = $signed(pl_r[0]) + $signed(pl_r[1]) + $signed(pl_r[2]);
  assign sh_w  = $signed(ph_r[0]) + $signed(ph_r[1]) + $signed(ph_r[2]);
  assign det_w = ($signed(sh_r) <<< EB) + $signed(sl_r);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c3_r <= cof_in;
    end
    if (en[1]) begin
      sl_r <= sl_w;
      sh_r <= sh_w;
      c4_r <= c3_r;
    end
    if (en[2]) begin
      det_r <= det_w;
      c5_r  <= c4_r;
    end
  end

  assign cof_out = c5_r;
  assign det     = det_r;

endmodule
`default_nettype wire

/* hw/rtl/m3i_div_lane.sv */
`default_nettype none
module m3i_div_lane import m3i_pkg::*; #(
  parameter int EB   = 32,
  parameter int FB   = 16,
  parameter bit DIAG = 1'b0
) (
  input  wire logic              clk,
  input  wire logic [EB+3:0]     en,
  input  wire logic [2*EB:0]     cof,
  input  wire logic [3*EB+3:0]   det,
  output logic      [EB-1:0]     res,
  output logic                   sat,
  output logic                   sing
);

  localparam int CW = 2 * EB + 1;
  localparam int DW = 3 * EB + 4;
  localparam int NW = CW + 2 * FB;
  localparam int XW = (NW > DW + EB) ? NW : DW + EB;
  localparam logic [EB:0]   HALF = {2'b01, {(EB-1){1'b0}}};
  localparam logic [EB-1:0] ONE  = (FB >= EB - 1) ? {1'b0, {(EB-1){1'b1}}}
                                                  : {{(EB-1){1'b0}}, 1'b1} << FB;

  // Magnitude stage
  logic [CW-1:0] ca_r;
  logic [DW-1:0] da_r;
  logic          neg_a_r, sing_a_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ca_r     <= cof[CW-1] ? (~cof + 1'b1) : cof;
      da_r     <= det[DW-1] ? (~det + 1'b1) : det;
      neg_a_r  <= (cof[CW-1] ^ det[DW-1]) && (cof != '0);
      sing_a_r <= (det == '0);
    end
  end

  // Overflow check and first partial remainder
  logic [NW-1:0] n_w;
  logic [XW-1:0] nx_w, dx_w, nsh_w;
  logic [DW:0]   r_b_r;
  logic [DW-1:0] d_b_r;
  logic [EB-1:0] nlo_b_r;
  logic          neg_b_r, big_b_r, sing_b_r;

  assign n_w   = {ca_r, {(2*FB){1'b0}}};
  assign nx_w  = XW'(n_w);
  assign dx_w  = XW'(da_r) << EB;
  assign nsh_w = nx_w >> EB;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      big_b_r  <= nx_w >= dx_w;
      r_b_r    <= nsh_w[DW:0];
      nlo_b_r  <= n_w[EB-1:0];
      d_b_r    <= da_r;
      neg_b_r  <= neg_a_r;
      sing_b_r <= sing_a_r;
    end
  end

  // One quotient bit per stage, MSB first
  logic [EB-1:0][DW:0]   r_s;
  logic [EB-1:0][DW-1:0] d_s;
  logic [EB-1:0][EB-1:0] q_s;
  logic [EB-1:0][EB-1:0] nlo_s;
  logic [EB-1:0]         neg_s, big_s, sing_s;

  for (genvar s = 0; s < EB; s++) begin : g_step
    logic [DW:0]   r_in, rs_w, diff_w;
    logic [DW-1:0] d_in;
    logic [EB-1:0] q_in, nlo_in;
    logic          neg_in, big_in, sing_in, ge_w;

    if (s == 0) begin : g_first
      assign r_in    = r_b_r;
      assign d_in    = d_b_r;
      assign q_in    = '0;
      assign nlo_in  = nlo_b_r;
      assign neg_in  = neg_b_r;
      assign big_in  = big_b_r;
      assign sing_in = sing_b_r;
    end else begin : g_next
      assign r_in    = r_s[s-1];
      assign d_in    = d_s[s-1];
      assign q_in    = q_s[s-1];
      assign nlo_in  = nlo_s[s-1];
      assign neg_in  = neg_s[s-1];
      assign big_in  = big_s[s-1];
      assign sing_in = sing_s[s-1];
    end

    assign rs_w   = {r_in[DW-1:0], nlo_in[EB-1]};
    assign ge_w   = rs_w >= {1'b0, d_in};
    assign diff_w = rs_w - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en[2+s]) begin
        r_s[s]    <= ge_w ? diff_w : rs_w;
        q_s[s]    <= {q_in[EB-2:0], ge_w};
        nlo_s[s]  <= {nlo_in[EB-2:0], 1'b0};
        d_s[s]    <= d_in;
        neg_s[s]  <= neg_in;
        big_s[s]  <= big_in;
        sing_s[s] <= sing_in;
      end
    end
  end

  // Round to nearest, ties away from zero
  logic [EB-1:0] q_r_r;
  logic          rnd_r, neg_r_r, big_r_r, sing_r_r;

  always_ff @(posedge clk) begin
    if (en[EB+2]) begin
      rnd_r    <= {r_s[EB-1], 1'b0} >= {2'b00, d_s[EB-1]};
      q_r_r    <= q_s[EB-1];
      neg_r_r  <= neg_s[EB-1];
      big_r_r  <= big_s[EB-1];
      sing_r_r <= sing_s[EB-1];
    end
  end

  // Saturate and apply sign
  logic [EB:0]   mag_w, lim_w, val_w;
  logic          ovf_w;
  logic [EB-1:0] res_w;
  logic [EB-1:0] res_r;
  logic          sat_r, sing_o_r;

  assign mag_w = {1'b0, q_r_r} + {{EB{1'b0}}, rnd_r};
  assign lim_w = neg_r_r ? HALF : HALF - 1'b1;
  assign ovf_w = big_r_r || (mag_w > lim_w);
  assign val_w = ovf_w ? lim_w : mag_w;
  assign res_w = neg_r_r ? (~val_w[EB-1:0] + 1'b1) : val_w[EB-1:0];

  always_ff @(posedge clk) begin
    if (en[EB+3]) begin
      if (sing_r_r) begin
        res_r <= DIAG ? ONE : '0;
        sat_r <= 1'b0;
      end else begin
        res_r <= res_w;
        sat_r <= ovf_w;
      end
      sing_o_r <= sing_r_r;
    end
  end

  assign res  = res_r;
  assign sat  = sat_r;
  assign sing = sing_o_r;

endmodule
`default_nettype wire

/* hw/rtl/matrix3_inverse_adjugate_core.sv */
`default_nettype none
// Channel   Handshake             Payload
// in_       in_valid / in_ready   in_e00 .. in_e22 (signed fixed point)
// out_      out_valid / out_ready out_r00 .. out_r22, out_status
//
// Fully pipelined: one matrix per cycle while out_ready keeps the output moving;
// the restoring divider takes one quotient bit a stage.
// Reset clears only the stage valid bits.
// A stage loads when it is empty or the stage after it advances, so bubbles
// are squeezed out and input is taken while a result waits at the output.
module matrix3_inverse_adjugate_core import m3i_pkg::*; #(
  parameter int ELEMENT_BITS  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [ELEMENT_BITS-1:0]  in_e00,
  input  wire logic signed [ELEMENT_BITS-1:0]  in_e01,
  input  wire logic signed [ELEMENT_BITS-1:0]  in_e02,
  input  wire logic signed [ELEMENT_BITS-1:0]  in_e10,
  input  wire logic signed [ELEMENT_BITS-1:0]  in_e11,
  input  wire logic signed [ELEMENT_BITS-1:0]  in_e12,
  input  wire logic signed [ELEMENT_BITS-1:0]  in_e20,
  input  wire logic signed [ELEMENT_BITS-1:0]  in_e21,
  input  wire logic signed [ELEMENT_BITS-1:0]  in_e22,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [ELEMENT_BITS-1:0]       out_r00,
  output logic signed [ELEMENT_BITS-1:0]       out_r01,
  output logic signed [ELEMENT_BITS-1:0]       out_r02,
  output logic signed [ELEMENT_BITS-1:0]       out_r10,
  output logic signed [ELEMENT_BITS-1:0]       out_r11,
  output logic signed [ELEMENT_BITS-1:0]       out_r12,
  output logic signed [ELEMENT_BITS-1:0]       out_r20,
  output logic signed [ELEMENT_BITS-1:0]       out_r21,
  output logic signed [ELEMENT_BITS-1:0]       out_r22,
  output logic [1:0]                           out_status
);

  localparam int EB  = ELEMENT_BITS;
  localparam int CW  = 2 * EB + 1;
  localparam int DW  = 3 * EB + 4;
  localparam int LS  = EB + 4;
  localparam int NST = 5 + LS;

  logic [NST-1:0] v_r, v_nxt, en;

  assign en[NST-1] = !v_r[NST-1] || out_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      if (!en[k]) begin
        v_nxt[k] = v_r[k];
      end else if (k == 0) begin
        v_nxt[k] = in_valid;
      end else begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  logic [NUM_ELEM-1:0][EB-1:0] e;
  logic [NUM_ELEM-1:0][CW-1:0] cof_a, cof_b;
  logic [2:0][EB-1:0]          row0;
  logic [DW-1:0]               det;

  assign e = {in_e22, in_e21, in_e20, in_e12, in_e11, in_e10, in_e02, in_e01, in_e00};

  m3i_cofactor #(.EB(EB)) u_cof (
    .clk  (clk),
    .en   (en[1:0]),
    .e    (e),
    .cof  (cof_a),
    .row0 (row0)
  );

  m3i_det #(.EB(EB)) u_det (
    .clk     (clk),
    .en      (en[4:2]),
    .cof_in  (cof_a),
    .row0    (row0),
    .cof_out (cof_b),
    .det     (det)
  );

  logic [NUM_ELEM-1:0][EB-1:0] res;
  logic [NUM_ELEM-1:0]         sat, sing;

  // Inverse (i,j) is cofactor (j,i) over the determinant
  for (genvar i = 0; i < 3; i++) begin : g_ri
    for (genvar j = 0; j < 3; j++) begin : g_rj
      m3i_div_lane #(.EB(EB), .FB(FRACTION_BITS), .DIAG(i == j)) u_lane (
        .clk  (clk),
        .en   (en[NST-1:5]),
        .cof  (cof_b[j*3+i]),
        .det  (det),
        .res  (res[i*3+j]),
        .sat  (sat[i*3+j]),
        .sing (sing[i*3+j])
      );
    end
  end

  assign out_r00 = res[0];
  assign out_r01 = res[1];
  assign out_r02 = res[2];
  assign out_r10 = res[3];
  assign out_r11 = res[4];
  assign out_r12 = res[5];
  assign out_r20 = res[6];
  assign out_r21 = res[7];
  assign out_r22 = res[8];

  assign out_status = sing[0] ? ST_SING : ((|sat) ? ST_SAT : ST_OK);

  a_no_code3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("unused status code produced");

  a_sing_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SING |->
      out_r01 == '0 && out_r10 == '0 && out_r00 == out_r11 && out_r11 == out_r22)
    else $error("singular result is not identity");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_ready |-> !in_ready)
    else $error("input taken while pipeline full and stalled");

endmodule
`default_nettype wire

/* sim/matrix3_inverse_adjugate_core_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module matrix3_inverse_adjugate_core_tb;
  import m3i_pkg::*;

  localparam int EW = 32;
  localparam int FW = 16;
  localparam int N_RANDOM = 930;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [255:0] wide_t;
  typedef struct { elem_t e[NUM_ELEM]; } matrix_t;
  typedef struct { elem_t r[NUM_ELEM]; logic [1:0] st; } inverse_t;

  class inverse_scoreboard;
    inverse_t inv_q[$];
    int errors = 0;
    int n_ok = 0, n_sing = 0, n_sat = 0, n_checked = 0;

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // round to nearest (ties away), then clamp to the element range
    function elem_t divide_round(wide_t cof, wide_t det, ref bit sat);
      logic [255:0] n, d, q, rem, mag, lim;
      bit neg;
      neg = cof[255] != det[255];
      n = (cof[255] ? -cof : cof) << (2 * FW);
      d = det[255] ? -det : det;
      q = n / d;
      rem = n % d;
      if ((rem << 1) >= d) q = q + 1;
      if (n == 0) neg = 0;
      lim = neg ? (256'd1 << (EW - 1)) : ((256'd1 << (EW - 1)) - 1);
      mag = q;
      if (mag > lim) begin
        sat = 1;
        mag = lim;
      end
      return neg ? elem_t'(-mag) : elem_t'(mag);
    endfunction

    function void note_input(matrix_t m);
      wide_t e[NUM_ELEM], c[NUM_ELEM], det;
      inverse_t x;
      bit sat;
      sat = 0;
      for (int i = 0; i < NUM_ELEM; i++) e[i] = m.e[i];
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          c[i*3+j] = e[((i+1)%3)*3+(j+1)%3] * e[((i+2)%3)*3+(j+2)%3]
                   - e[((i+1)%3)*3+(j+2)%3] * e[((i+2)%3)*3+(j+1)%3];
      det = e[0] * c[0] + e[1] * c[1] + e[2] * c[2];
      if (det == 0) begin
        for (int i = 0; i < NUM_ELEM; i++) x.r[i] = '0;
        x.r[0] = elem_t'(1) <<< FW;
        x.r[4] = x.r[0];
        x.r[8] = x.r[0];
        x.st = ST_SING;
      end else begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            x.r[i*3+j] = divide_round(c[j*3+i], det, sat);
        x.st = sat ? ST_SAT : ST_OK;
      end
      inv_q.push_back(x);
    endfunction

    task check(inverse_t got);
      inverse_t exp_inv;
      if (inv_q.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      exp_inv = inv_q.pop_front();
      n_checked++;
      for (int i = 0; i < NUM_ELEM; i++)
        if (got.r[i] !== exp_inv.r[i])
          report($sformatf("r%0d%0d got %h want %h", i / 3, i % 3, got.r[i], exp_inv.r[i]));
      if (got.st !== exp_inv.st)
        report($sformatf("status got %0d want %0d", got.st, exp_inv.st));
      case (exp_inv.st)
        ST_SING: n_sing++;
        ST_SAT:  n_sat++;
        default: n_ok++;
      endcase
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic out_ready = 0;
  logic in_ready, out_valid;
  elem_t cur[NUM_ELEM];
  elem_t res[NUM_ELEM];
  logic [1:0] out_status;
  int sent = 0;
  inverse_scoreboard sb = new();

  initial for (int i = 0; i < NUM_ELEM; i++) cur[i] = '0;

  matrix3_inverse_adjugate_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_e00(cur[0]), .in_e01(cur[1]), .in_e02(cur[2]),
    .in_e10(cur[3]), .in_e11(cur[4]), .in_e12(cur[5]),
    .in_e20(cur[6]), .in_e21(cur[7]), .in_e22(cur[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_r00(res[0]), .out_r01(res[1]), .out_r02(res[2]),
    .out_r10(res[3]), .out_r11(res[4]), .out_r12(res[5]),
    .out_r20(res[6]), .out_r21(res[7]), .out_r22(res[8]),
    .out_status(out_status)
  );

  initial forever #5 clk = ~clk;

  function automatic bit quiet_stretch();
    return sent >= 400 && sent < 560;
  endfunction

  task automatic send(matrix_t m);
    @(negedge clk);
    while (!quiet_stretch() && $urandom_range(0, 99) < 35) begin
      in_valid = 0;
      @(negedge clk);
    end
    for (int i = 0; i < NUM_ELEM; i++) cur[i] = m.e[i];
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(m);
    sent++;
  endtask

  function automatic elem_t pick_elem(int kind);
    case (kind)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return elem_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return elem_t'($urandom_range(0, 4)) - 2;
          default: return 32'sh0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic matrix_t diag(elem_t a, elem_t b, elem_t c);
    matrix_t m;
    for (int i = 0; i < NUM_ELEM; i++) m.e[i] = '0;
    m.e[0] = a; m.e[4] = b; m.e[8] = c;
    return m;
  endfunction

  task automatic run_directed();
    matrix_t m;
    send(diag(0, 0, 0));
    send(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
    send(diag(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send(diag(1, 1, 1));
    send(diag(-1, 1, -1));
    send(diag(32'sh0002_0000, -32'sh0002_0000, 32'sh0004_0000));
    send(diag(32'sh0003_0000, 32'sh0000_8000, -32'sh0003_0000));
    for (int i = 0; i < NUM_ELEM; i++) m.e[i] = 32'sh7fff_ffff;
    send(m);
    for (int i = 0; i < NUM_ELEM; i++) m.e[i] = 32'sh8000_0000;
    send(m);
    for (int i = 0; i < NUM_ELEM; i++) m.e[i] = -1;
    m.e[0] = 32'sh8000_0000; m.e[4] = 32'sh7fff_ffff;
    send(m);
    for (int i = 0; i < NUM_ELEM; i++) m.e[i] = (i % 2) ? 32'sh5555_5555 : 32'shAAAA_AAAA;
    send(m);
    // permutation: off-diagonal cofactors, negative determinant
    m = diag(0, 0, 32'sh0001_0000);
    m.e[1] = 32'sh0002_0000; m.e[3] = 32'sh0001_8000;
    send(m);
    for (int i = 0; i < NUM_ELEM; i++) m.e[i] = pick_elem(1);
    send(m);
    for (int i = 0; i < NUM_ELEM; i++) m.e[i] = pick_elem(0);
    send(m);
  endtask

  task automatic run_random();
    matrix_t m;
    int kind, shape;
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      kind = kind < 3 ? 0 : kind < 6 ? 1 : kind < 8 ? 2 : 3;
      for (int i = 0; i < NUM_ELEM; i++) m.e[i] = pick_elem(kind);
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        // duplicate row: determinant exactly zero
        for (int j = 0; j < 3; j++) m.e[6+j] = m.e[j];
      end else if (shape == 1) begin
        for (int i = 0; i < NUM_ELEM; i++)
          if (i % 4 != 0) m.e[i] = elem_t'($urandom_range(0, 2)) - 1;
      end
      send(m);
    end
  endtask

  // result side: random back-pressure, one long hold-off to fill the pipe
  initial begin
    bit held = 0;
    inverse_t got;
    forever begin
      @(negedge clk);
      if (!held && sent >= 120) begin
        held = 1;
        out_ready = 0;
        repeat (300) @(negedge clk);
      end
      out_ready = quiet_stretch() ? 1'b1 : ($urandom_range(0, 99) >= 35);
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        for (int i = 0; i < NUM_ELEM; i++) got.r[i] = res[i];
        got.st = out_status;
        sb.check(got);
      end
    end
  end

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    run_directed();
    run_random();
    @(negedge clk);
    in_valid = 0;
    waited = 0;
    while (sb.inv_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (sb.inv_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.inv_q.size()));
    $display("Sent %0d matrices, checked %0d inverses: %0d regular, %0d singular, %0d saturated",
             sent, sb.n_checked, sb.n_ok, sb.n_sing, sb.n_sat);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
